// ===== rtl/bbm_pkg.sv =====
package bbm_pkg;

    // Word format
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Normalizer widths
    localparam int NORM_BITS = 30;
    localparam int DIFF_W    = WORD_BITS + 1;
    localparam int MAG_W     = WORD_BITS + 1;
    localparam int SUM_W     = 2 * NORM_BITS + 2;
    localparam int ROOT_W    = NORM_BITS + 1;
    localparam int REM_W     = ROOT_W + 3;
    localparam int DR_W      = ROOT_W + 1;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int DVD_W     = NORM_BITS + FRAC_BITS + 1;
    localparam int UNIT_W    = FRAC_BITS + 2;
    localparam int UP_W      = FRAC_BITS + 3;

    // Iteration schedule of the square root and divider pipelines
    localparam int SQ_STEPS = ROOT_W;
    localparam int SQ_PER   = 2;
    localparam int SQ_STG   = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
    localparam int DV_STEPS = Q_W;
    localparam int DV_PER   = 2;
    localparam int DV_STG   = (DV_STEPS + DV_PER - 1) / DV_PER;

    // Register file
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

    // Billboard modes
    localparam logic [1:0] MODE_FULL   = 2'd0;
    localparam logic [1:0] MODE_LOCK_X = 2'd1;
    localparam logic [1:0] MODE_LOCK_Y = 2'd2;
    localparam logic [1:0] MODE_LOCK_Z = 2'd3;

    typedef logic [2:0][DIFF_W-1:0] dvec_t;
    typedef logic [2:0][UNIT_W-1:0] uvec_t;

    // Data that rides alongside the normalizers
    typedef struct packed {
        logic [2:0][WORD_BITS-1:0] pos;
        logic [2:0][WORD_BITS-1:0] scl;
        logic [2:0][UNIT_W-1:0]    fwd;
    } side_t;

endpackage

// ===== rtl/bbm_norm.sv =====
module bbm_norm
    import bbm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  dvec_t in_vec,
    input  side_t in_side,
    output logic  out_valid,
    input  logic  out_stall,
    output uvec_t out_vec,
    output side_t out_side
);

    localparam int ST_MAG   = 0;
    localparam int ST_SHIFT = 1;
    localparam int ST_SQUARE = 2;
    localparam int ST_SQ0   = 3;
    localparam int ST_DV0   = ST_SQ0 + SQ_STG + 1;
    localparam int ST_OUT   = ST_DV0 + DV_STG + 1;
    localparam int NSTG     = ST_OUT + 1;
    localparam int BL_W     = $clog2(MAG_W + 1);
    localparam int EXT_W    = MAG_W + NORM_BITS - 1;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            sgn;
        logic [MAG_W-1:0]      mx;
        side_t                 side;
    } mag_t;

    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] m;
        logic [2:0]                sgn;
        logic                      zero;
        side_t                     side;
    } carry_t;

    typedef struct packed {
        logic [2:0][2*NORM_BITS-1:0] sq;
        carry_t                      c;
    } sqr_t;

    typedef struct packed {
        logic [SUM_W-1:0]  x;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        carry_t            c;
    } sq_t;

    typedef struct packed {
        logic [2:0][DR_W-1:0] rem;
        logic [2:0][Q_W-1:0]  lo;
        logic [2:0][Q_W-1:0]  q;
        logic [ROOT_W-1:0]    len;
        logic [2:0]           sgn;
        logic                 zero;
        side_t                side;
    } dv_t;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   adv;

    mag_t   mag_reg, mag_next;
    carry_t shf_reg, shf_next;
    sqr_t   sqr_reg, sqr_next;
    sq_t    sq_reg  [SQ_STG+1];
    sq_t    sq_next [SQ_STG+1];
    dv_t    dv_reg  [DV_STG+1];
    dv_t    dv_next [DV_STG+1];
    uvec_t  out_vec_reg, out_vec_next;
    side_t  out_side_reg;

    // Stall ripple: a stage moves when it is empty or its successor moves
    always_comb
    begin
        adv[NSTG] = !out_stall;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_vec   = out_vec_reg;
    assign out_side  = out_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Magnitudes, signs and largest magnitude
    always_comb
    begin
        logic signed [DIFF_W-1:0] v;
        mag_next    = '0;
        mag_next.side = in_side;
        for (int i = 0; i < 3; i++)
        begin
            v = $signed(in_vec[i]);
            mag_next.sgn[i] = v[DIFF_W-1];
            mag_next.mag[i] = v[DIFF_W-1] ? MAG_W'(-v) : MAG_W'(v);
        end
        mag_next.mx = mag_next.mag[0];
        if (mag_next.mag[1] > mag_next.mx)
        begin
            mag_next.mx = mag_next.mag[1];
        end
        if (mag_next.mag[2] > mag_next.mx)
        begin
            mag_next.mx = mag_next.mag[2];
        end
    end

    // Scale so the largest magnitude has NORM_BITS significant bits
    always_comb
    begin
        logic [BL_W-1:0]  bl;
        logic [BL_W-1:0]  shamt;
        logic [EXT_W-1:0] ext;
        bl = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (mag_reg.mx[i])
            begin
                bl = BL_W'(i + 1);
            end
        end
        shamt = (bl == '0) ? '0 : bl - BL_W'(1);
        shf_next.sgn  = mag_reg.sgn;
        shf_next.zero = (mag_reg.mx == '0);
        shf_next.side = mag_reg.side;
        for (int i = 0; i < 3; i++)
        begin
            ext = {mag_reg.mag[i], {(NORM_BITS-1){1'b0}}} >> shamt;
            shf_next.m[i] = ext[NORM_BITS-1:0];
        end
    end

    // Squares
    always_comb
    begin
        logic [2*NORM_BITS-1:0] a;
        sqr_next.c = shf_reg;
        for (int i = 0; i < 3; i++)
        begin
            a = (2*NORM_BITS)'(shf_reg.m[i]);
            sqr_next.sq[i] = a * a;
        end
    end

    // Sum of squares seeds the square root
    always_comb
    begin
        sq_next[0].x    = SUM_W'(sqr_reg.sq[0]) + SUM_W'(sqr_reg.sq[1])
                        + SUM_W'(sqr_reg.sq[2]);
        sq_next[0].rem  = '0;
        sq_next[0].root = '0;
        sq_next[0].c    = sqr_reg.c;
    end

    // Square root, two result bits per stage
    always_comb
    begin
        sq_t                cur;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;
        for (int s = 1; s <= SQ_STG; s++)
        begin
            cur = sq_reg[s-1];
            for (int t = 0; t < SQ_PER; t++)
            begin
                if ((s - 1) * SQ_PER + t < SQ_STEPS)
                begin
                    rem_sh = {cur.rem[REM_W-3:0], cur.x[SUM_W-1 -: 2]};
                    trial  = REM_W'({cur.root, 2'b01});
                    cur.x  = cur.x << 2;
                    if (rem_sh >= trial)
                    begin
                        cur.rem  = rem_sh - trial;
                        cur.root = {cur.root[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        cur.rem  = rem_sh;
                        cur.root = {cur.root[ROOT_W-2:0], 1'b0};
                    end
                end
            end
            sq_next[s] = cur;
        end
    end

    // Divider setup: dividend is m << FRAC_BITS plus half the length
    always_comb
    begin
        logic [DVD_W-1:0] dvd;
        dv_next[0].len  = sq_reg[SQ_STG].root;
        dv_next[0].sgn  = sq_reg[SQ_STG].c.sgn;
        dv_next[0].zero = sq_reg[SQ_STG].c.zero;
        dv_next[0].side = sq_reg[SQ_STG].c.side;
        dv_next[0].q    = '0;
        for (int i = 0; i < 3; i++)
        begin
            dvd = DVD_W'({sq_reg[SQ_STG].c.m[i], {FRAC_BITS{1'b0}}})
                + DVD_W'(sq_reg[SQ_STG].root >> 1);
            dv_next[0].rem[i] = DR_W'(dvd[DVD_W-1:Q_W]);
            dv_next[0].lo[i]  = dvd[Q_W-1:0];
        end
    end

    // Restoring division, two quotient bits per stage
    always_comb
    begin
        dv_t             cur;
        logic [DR_W-1:0] sh;
        for (int s = 1; s <= DV_STG; s++)
        begin
            cur = dv_reg[s-1];
            for (int t = 0; t < DV_PER; t++)
            begin
                if ((s - 1) * DV_PER + t < DV_STEPS)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sh = {cur.rem[i][DR_W-2:0], cur.lo[i][Q_W-1]};
                        cur.lo[i] = cur.lo[i] << 1;
                        if (sh >= DR_W'(cur.len))
                        begin
                            cur.rem[i] = sh - DR_W'(cur.len);
                            cur.q[i]   = {cur.q[i][Q_W-2:0], 1'b1};
                        end
                        else
                        begin
                            cur.rem[i] = sh;
                            cur.q[i]   = {cur.q[i][Q_W-2:0], 1'b0};
                        end
                    end
                end
            end
            dv_next[s] = cur;
        end
    end

    // Sign restore; zero vector gives zero
    always_comb
    begin
        logic [UNIT_W-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = UNIT_W'(dv_reg[DV_STG].q[i]);
            if (dv_reg[DV_STG].zero)
            begin
                out_vec_next[i] = '0;
            end
            else
            begin
                out_vec_next[i] = dv_reg[DV_STG].sgn[i] ? -q : q;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv[ST_MAG])
        begin
            mag_reg <= mag_next;
        end
        if (adv[ST_SHIFT])
        begin
            shf_reg <= shf_next;
        end
        if (adv[ST_SQUARE])
        begin
            sqr_reg <= sqr_next;
        end
        for (int s = 0; s <= SQ_STG; s++)
        begin
            if (adv[ST_SQ0+s])
            begin
                sq_reg[s] <= sq_next[s];
            end
        end
        for (int s = 0; s <= DV_STG; s++)
        begin
            if (adv[ST_DV0+s])
            begin
                dv_reg[s] <= dv_next[s];
            end
        end
        if (adv[ST_OUT])
        begin
            out_vec_reg  <= out_vec_next;
            out_side_reg <= dv_reg[DV_STG].side;
        end
    end

endmodule

// ===== rtl/billboard_matrix.sv =====
// Stages: 1 difference stage, two 31-stage normalizers and 6 stages for the
// up vector and scaling.
// Throughput: one item per cycle while out_stall is low; the square root and
// divider pipelines retire two bits per stage, so no stage iterates.
// Reset: rst_n clears all valid bits and the camera registers to zero.
module billboard_matrix
    import bbm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [WORD_BITS-1:0]        pwdata,
    output logic [WORD_BITS-1:0]        prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [WORD_BITS-1:0] pos_x,
    input  logic signed [WORD_BITS-1:0] pos_y,
    input  logic signed [WORD_BITS-1:0] pos_z,
    input  logic signed [WORD_BITS-1:0] scale_x,
    input  logic signed [WORD_BITS-1:0] scale_y,
    input  logic signed [WORD_BITS-1:0] scale_z,
    input  logic [1:0]                  mode,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [WORD_BITS-1:0] right_x,
    output logic signed [WORD_BITS-1:0] right_y,
    output logic signed [WORD_BITS-1:0] right_z,
    output logic signed [WORD_BITS-1:0] up_x,
    output logic signed [WORD_BITS-1:0] up_y,
    output logic signed [WORD_BITS-1:0] up_z,
    output logic signed [WORD_BITS-1:0] fwd_x,
    output logic signed [WORD_BITS-1:0] fwd_y,
    output logic signed [WORD_BITS-1:0] fwd_z,
    output logic signed [WORD_BITS-1:0] trans_x,
    output logic signed [WORD_BITS-1:0] trans_y,
    output logic signed [WORD_BITS-1:0] trans_z
);

    localparam int POST_STG = 6;
    localparam int ST_U1 = 0;
    localparam int ST_U2 = 1;
    localparam int ST_U3 = 2;
    localparam int ST_M0 = 3;
    localparam int ST_M1 = 4;
    localparam int ST_M2 = 5;
    localparam int PP_W  = 2 * UNIT_W;
    localparam int DP_W  = PP_W + 1;
    localparam int PR_W  = UP_W + WORD_BITS;

    typedef struct packed {
        logic [5:0][PP_W-1:0] p;
        uvec_t                r;
        side_t                side;
    } u1_t;

    typedef struct packed {
        logic [2:0][DP_W-1:0] d;
        uvec_t                r;
        side_t                side;
    } u2_t;

    typedef struct packed {
        logic [2:0][UP_W-1:0] u;
        uvec_t                r;
        side_t                side;
    } u3_t;

    typedef struct packed {
        logic [8:0][UP_W-1:0]      ma;
        logic [2:0][WORD_BITS-1:0] mb;
        logic [8:0]                neg;
        logic [2:0][WORD_BITS-1:0] pos;
    } m0_t;

    typedef struct packed {
        logic [8:0][PR_W-1:0]      p;
        logic [8:0]                neg;
        logic [2:0][WORD_BITS-1:0] pos;
    } m1_t;

    typedef struct packed {
        logic [8:0][WORD_BITS-1:0] res;
        logic [2:0][WORD_BITS-1:0] pos;
    } m2_t;

    logic signed [WORD_BITS-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [REG_IDX_W-1:0]        reg_idx;
    logic                        cfg_wr;

    logic  t0_vld_reg;
    logic  t0_adv;
    dvec_t t0_d_reg, t0_d_next;
    side_t t0_side_reg, t0_side_next;

    logic  n1_in_stall, n1_out_valid, n2_in_stall, n2_out_valid;
    uvec_t n1_vec, n2_in_vec_u, n2_vec;
    dvec_t n2_in_vec;
    side_t n1_side, n2_in_side, n2_side;

    logic [POST_STG-1:0] tv_reg;
    logic [POST_STG:0]   tadv;

    u1_t u1_reg, u1_next;
    u2_t u2_reg, u2_next;
    u3_t u3_reg, u3_next;
    m0_t m0_reg, m0_next;
    m1_t m1_reg, m1_next;
    m2_t m2_reg, m2_next;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (reg_idx == REG_CAMERA_X)
            begin
                cam_x_reg <= pwdata;
            end
            if (reg_idx == REG_CAMERA_Y)
            begin
                cam_y_reg <= pwdata;
            end
            if (reg_idx == REG_CAMERA_Z)
            begin
                cam_z_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CAMERA_X: prdata = cam_x_reg;
            REG_CAMERA_Y: prdata = cam_y_reg;
            REG_CAMERA_Z: prdata = cam_z_reg;
            default:      prdata = '0;
        endcase
    end

    // Object-to-camera vector with the locked axis cleared
    always_comb
    begin
        t0_d_next[0] = DIFF_W'(cam_x_reg) - DIFF_W'(pos_x);
        t0_d_next[1] = DIFF_W'(cam_y_reg) - DIFF_W'(pos_y);
        t0_d_next[2] = DIFF_W'(cam_z_reg) - DIFF_W'(pos_z);
        unique case (mode)
            MODE_FULL:   ;
            MODE_LOCK_X: t0_d_next[0] = '0;
            MODE_LOCK_Y: t0_d_next[1] = '0;
            MODE_LOCK_Z: t0_d_next[2] = '0;
            default:     ;
        endcase
        t0_side_next.pos = {pos_z, pos_y, pos_x};
        t0_side_next.scl = {scale_z, scale_y, scale_x};
        t0_side_next.fwd = '0;
    end

    assign t0_adv   = !t0_vld_reg || !n1_in_stall;
    assign in_stall = !t0_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_vld_reg <= 1'b0;
        end
        else if (t0_adv)
        begin
            t0_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t0_adv)
        begin
            t0_d_reg    <= t0_d_next;
            t0_side_reg <= t0_side_next;
        end
    end

    // forward = -normalize(toCam)
    bbm_norm u_norm_fwd
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t0_vld_reg),
        .in_stall  (n1_in_stall),
        .in_vec    (t0_d_reg),
        .in_side   (t0_side_reg),
        .out_valid (n1_out_valid),
        .out_stall (n2_in_stall),
        .out_vec   (n1_vec),
        .out_side  (n1_side)
    );

    // right direction = (fz, 0, -fx) with f = -n1
    always_comb
    begin
        n2_in_vec_u[0] = -n1_vec[2];
        n2_in_vec_u[1] = '0;
        n2_in_vec_u[2] = n1_vec[0];
        for (int i = 0; i < 3; i++)
        begin
            n2_in_vec[i] = DIFF_W'($signed(n2_in_vec_u[i]));
        end
        n2_in_side     = n1_side;
        n2_in_side.fwd = {-n1_vec[2], -n1_vec[1], -n1_vec[0]};
    end

    bbm_norm u_norm_right
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n1_out_valid),
        .in_stall  (n2_in_stall),
        .in_vec    (n2_in_vec),
        .in_side   (n2_in_side),
        .out_valid (n2_out_valid),
        .out_stall (!tadv[0]),
        .out_vec   (n2_vec),
        .out_side  (n2_side)
    );

    // Back-end stall ripple
    always_comb
    begin
        tadv[POST_STG] = !out_stall;
        for (int i = POST_STG - 1; i >= 0; i--)
        begin
            tadv[i] = !tv_reg[i] || tadv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= '0;
        end
        else
        begin
            if (tadv[0])
            begin
                tv_reg[0] <= n2_out_valid;
            end
            for (int i = 1; i < POST_STG; i++)
            begin
                if (tadv[i])
                begin
                    tv_reg[i] <= tv_reg[i-1];
                end
            end
        end
    end

    // Up vector cross products
    always_comb
    begin
        logic signed [UNIT_W-1:0] f0, f1, f2, r0, r1, r2;
        logic signed [PP_W-1:0]   p0, p1, p2, p3, p4, p5;
        f0 = $signed(n2_side.fwd[0]);
        f1 = $signed(n2_side.fwd[1]);
        f2 = $signed(n2_side.fwd[2]);
        r0 = $signed(n2_vec[0]);
        r1 = $signed(n2_vec[1]);
        r2 = $signed(n2_vec[2]);
        p0 = f1 * r2;
        p1 = f2 * r1;
        p2 = f2 * r0;
        p3 = f0 * r2;
        p4 = f0 * r1;
        p5 = f1 * r0;
        u1_next.p    = {p5, p4, p3, p2, p1, p0};
        u1_next.r    = n2_vec;
        u1_next.side = n2_side;
    end

    // Differences
    always_comb
    begin
        logic signed [PP_W-1:0] pa, pb;
        for (int k = 0; k < 3; k++)
        begin
            pa = $signed(u1_reg.p[2*k]);
            pb = $signed(u1_reg.p[2*k+1]);
            u2_next.d[k] = DP_W'(pa) - DP_W'(pb);
        end
        u2_next.r    = u1_reg.r;
        u2_next.side = u1_reg.side;
    end

    // Round to nearest, ties away from zero
    always_comb
    begin
        logic [DP_W-1:0] mag;
        logic [DP_W-1:0] rnd;
        logic [UP_W-1:0] q;
        for (int k = 0; k < 3; k++)
        begin
            mag = u2_reg.d[k][DP_W-1] ? -u2_reg.d[k] : u2_reg.d[k];
            rnd = (mag + DP_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            q   = rnd[UP_W-1:0];
            u3_next.u[k] = u2_reg.d[k][DP_W-1] ? -q : q;
        end
        u3_next.r    = u2_reg.r;
        u3_next.side = u2_reg.side;
    end

    // Operand magnitudes and product signs
    always_comb
    begin
        logic signed [UP_W-1:0]      a;
        logic signed [WORD_BITS-1:0] b;
        for (int k = 0; k < 9; k++)
        begin
            if (k < 3)
            begin
                a = UP_W'($signed(u3_reg.r[k]));
                b = $signed(u3_reg.side.scl[0]);
            end
            else if (k < 6)
            begin
                a = $signed(u3_reg.u[k-3]);
                b = $signed(u3_reg.side.scl[1]);
            end
            else
            begin
                a = UP_W'($signed(u3_reg.side.fwd[k-6]));
                b = $signed(u3_reg.side.scl[2]);
            end
            m0_next.ma[k]  = a[UP_W-1] ? -a : a;
            m0_next.neg[k] = a[UP_W-1] ^ b[WORD_BITS-1];
        end
        for (int j = 0; j < 3; j++)
        begin
            b = $signed(u3_reg.side.scl[j]);
            m0_next.mb[j] = b[WORD_BITS-1] ? -b : b;
        end
        m0_next.pos = u3_reg.side.pos;
    end

    // Scale products
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            m1_next.p[k] = PR_W'(m0_reg.ma[k]) * PR_W'(m0_reg.mb[k/3]);
        end
        m1_next.neg = m0_reg.neg;
        m1_next.pos = m0_reg.pos;
    end

    // Round and saturate
    always_comb
    begin
        logic [PR_W-1:0]      mag;
        logic                 sat;
        logic [WORD_BITS-1:0] lo;
        for (int k = 0; k < 9; k++)
        begin
            mag = (m1_reg.p[k] + PR_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            sat = (mag >= (PR_W'(1) << (WORD_BITS - 1)));
            lo  = mag[WORD_BITS-1:0];
            if (m1_reg.neg[k])
            begin
                m2_next.res[k] = sat ? {1'b1, {(WORD_BITS-1){1'b0}}} : -lo;
            end
            else
            begin
                m2_next.res[k] = sat ? {1'b0, {(WORD_BITS-1){1'b1}}} : lo;
            end
        end
        m2_next.pos = m1_reg.pos;
    end

    always_ff @(posedge clk)
    begin
        if (tadv[ST_U1])
        begin
            u1_reg <= u1_next;
        end
        if (tadv[ST_U2])
        begin
            u2_reg <= u2_next;
        end
        if (tadv[ST_U3])
        begin
            u3_reg <= u3_next;
        end
        if (tadv[ST_M0])
        begin
            m0_reg <= m0_next;
        end
        if (tadv[ST_M1])
        begin
            m1_reg <= m1_next;
        end
        if (tadv[ST_M2])
        begin
            m2_reg <= m2_next;
        end
    end

    // Result transfer
    assign out_valid = tv_reg[ST_M2];
    assign right_x   = m2_reg.res[0];
    assign right_y   = m2_reg.res[1];
    assign right_z   = m2_reg.res[2];
    assign up_x      = m2_reg.res[3];
    assign up_y      = m2_reg.res[4];
    assign up_z      = m2_reg.res[5];
    assign fwd_x     = m2_reg.res[6];
    assign fwd_y     = m2_reg.res[7];
    assign fwd_z     = m2_reg.res[8];
    assign trans_x   = m2_reg.pos[0];
    assign trans_y   = m2_reg.pos[1];
    assign trans_z   = m2_reg.pos[2];

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import bbm_pkg::*;

    typedef longint vec3_t [3];
    typedef logic [11:0][WORD_BITS-1:0] matrix_t;
    typedef struct packed {
        logic [5:0][WORD_BITS-1:0] w;   // pos x/y/z, scale x/y/z
        logic [1:0]                mode;
    } obj_t;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 80;
    localparam int WDOG_LIMIT  = 3000;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [WORD_BITS-1:0]        pwdata;
    logic [WORD_BITS-1:0]        prdata;
    logic                        pready;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [WORD_BITS-1:0] pos_x, pos_y, pos_z;
    logic signed [WORD_BITS-1:0] scale_x, scale_y, scale_z;
    logic [1:0]                  mode;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [WORD_BITS-1:0] right_x, right_y, right_z;
    logic signed [WORD_BITS-1:0] up_x, up_y, up_z;
    logic signed [WORD_BITS-1:0] fwd_x, fwd_y, fwd_z;
    logic signed [WORD_BITS-1:0] trans_x, trans_y, trans_z;

    // testbench copy of the camera registers
    logic signed [WORD_BITS-1:0] cam [3];

    obj_t    pending_objs [$];
    matrix_t expected_matrices [$];
    string   field_name [12] = '{"right_x", "right_y", "right_z", "up_x", "up_y", "up_z",
                                 "fwd_x", "fwd_y", "fwd_z", "trans_x", "trans_y", "trans_z"};

    int  send_idle_pct;
    int  stall_pct;
    int  hold_req;
    int  hold_seen;
    int  hold_left;
    logic took;
    int  errors;
    int  n_in;
    int  n_out;
    int  quiet_cycles;

    billboard_matrix u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z), .mode(mode),
        .out_valid(out_valid), .out_stall(out_stall),
        .right_x(right_x), .right_y(right_y), .right_z(right_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z),
        .fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
        .trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // integer square root, floor
    function automatic bit [63:0] isqrt(bit [63:0] x);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // scale to 30 significant bits, then divide by the length
    function automatic vec3_t unit_vec(vec3_t v);
        vec3_t     o;
        bit [63:0] m [3];
        bit [63:0] mx;
        bit [63:0] sum;
        bit [63:0] len;
        bit [63:0] q;
        int        bl;
        mx = 0;
        sum = 0;
        bl = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            o = '{0, 0, 0};
            return o;
        end
        while (bl < 64 && (mx >> bl) != 0)
            bl++;
        for (int i = 0; i < 3; i++)
        begin
            if (bl > NORM_BITS)
                m[i] >>= (bl - NORM_BITS);
            else
                m[i] <<= (NORM_BITS - bl);
            sum += m[i] * m[i];
        end
        len = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + len / 2) / len;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    // drop the fraction, nearest with ties away from zero
    function automatic longint round_q(longint p);
        bit [63:0] m;
        m = p < 0 ? -p : p;
        m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return p < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [WORD_BITS-1:0] mul_sat(longint a, longint b);
        longint r;
        longint lim;
        lim = longint'(1) << (WORD_BITS - 1);
        r = round_q(a * b);
        if (r >= lim)
            r = lim - 1;
        else if (r < -lim)
            r = -lim;
        return r[WORD_BITS-1:0];
    endfunction

    function automatic matrix_t billboard_of(obj_t o);
        vec3_t   d, f, rv, r, u;
        longint  sc [3];
        matrix_t mat;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'(cam[i]) - longint'($signed(o.w[i]));
            sc[i] = longint'($signed(o.w[3 + i]));
        end
        if (o.mode != MODE_FULL)
            d[o.mode - 1] = 0;
        f = unit_vec(d);
        for (int i = 0; i < 3; i++)
            f[i] = -f[i];
        rv = '{f[2], 0, -f[0]};
        r = unit_vec(rv);
        u[0] = round_q(f[1] * r[2] - f[2] * r[1]);
        u[1] = round_q(f[2] * r[0] - f[0] * r[2]);
        u[2] = round_q(f[0] * r[1] - f[1] * r[0]);
        for (int i = 0; i < 3; i++)
        begin
            mat[i]     = mul_sat(r[i], sc[0]);
            mat[3 + i] = mul_sat(u[i], sc[1]);
            mat[6 + i] = mul_sat(f[i], sc[2]);
            mat[9 + i] = o.w[i];
        end
        return mat;
    endfunction

    // append to the queue of objects waiting to be sent
    function automatic void add_obj(obj_t o);
        pending_objs = {pending_objs, o};
    endfunction

    // append to the queue of expected results
    function automatic void add_expected(matrix_t m);
        expected_matrices = {expected_matrices, m};
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000;
            3: return $urandom_range(0, 1) ? 32'hffff_0000 : 32'h0;
            4, 5: return WORD_BITS'(int'($urandom_range(0, 2 ** 22)) - 2 ** 21);
            default: return $urandom;
        endcase
    endfunction

    // positions often share camera components to hit the degenerate cases
    function automatic obj_t rand_obj();
        obj_t o;
        for (int i = 0; i < 6; i++)
            o.w[i] = rand_word();
        for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 4) == 0)
                o.w[i] = cam[i];
        o.mode = 2'($urandom_range(0, 3));
        return o;
    endfunction

    function automatic obj_t make_obj(logic [WORD_BITS-1:0] px, logic [WORD_BITS-1:0] py,
                                      logic [WORD_BITS-1:0] pz, logic [WORD_BITS-1:0] sx,
                                      logic [WORD_BITS-1:0] sy, logic [WORD_BITS-1:0] sz,
                                      logic [1:0] md);
        obj_t o;
        o.w = {sz, sy, sx, pz, py, px};
        o.mode = md;
        return o;
    endfunction

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [WORD_BITS-1:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'(idx) << 2;
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        cam[idx] = val;
    endtask

    task automatic set_camera(logic [WORD_BITS-1:0] cx, logic [WORD_BITS-1:0] cy,
                              logic [WORD_BITS-1:0] cz);
        reg_write(REG_CAMERA_X, cx);
        reg_write(REG_CAMERA_Y, cy);
        reg_write(REG_CAMERA_Z, cz);
    endtask

    // sender: new transfer offered at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || took))
        begin
            if (pending_objs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                obj_t o;
                o = pending_objs.pop_front();
                {pos_x, pos_y, pos_z} <= {o.w[0], o.w[1], o.w[2]};
                {scale_x, scale_y, scale_z} <= {o.w[3], o.w[4], o.w[5]};
                mode <= o.mode;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stall plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        out_stall <= (hold_left > 1) || (hold_req != hold_seen) ||
                     ($urandom_range(0, 99) < stall_pct);
    end

    // input transfers feed the predictor; output transfers are checked
    always @(posedge clk)
    begin
        took <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                add_expected(billboard_of(
                    make_obj(pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, mode)));
                n_in++;
            end
            if (out_valid && !out_stall)
            begin
                matrix_t got;
                matrix_t want;
                got = {trans_z, trans_y, trans_x, fwd_z, fwd_y, fwd_x,
                       up_z, up_y, up_x, right_z, right_y, right_x};
                n_out++;
                if (expected_matrices.size() == 0)
                begin
                    $display("%0t: unexpected result transfer", $time);
                    errors++;
                end
                else
                begin
                    want = expected_matrices.pop_front();
                    for (int i = 0; i < 12; i++)
                        if (got[i] !== want[i])
                        begin
                            $display("%0t: %s expected %h got %h", $time, field_name[i],
                                     want[i], got[i]);
                            errors++;
                        end
                end
            end
            // watchdog on transfer-free cycles
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("%0t: timeout, no transfers", $time);
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {pos_x, pos_y, pos_z, scale_x, scale_y, scale_z} = '0;
        mode = MODE_FULL;
        cam = '{0, 0, 0};
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        took = 1'b0;
        errors = 0;
        n_in = 0;
        n_out = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 8; ph++)
        begin
            // camera: origin, both extremes, a mixed setting, then random
            case (ph)
                0: set_camera(32'h0, 32'h0, 32'h0);
                1: set_camera(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
                2: set_camera(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                3: set_camera(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
                default: set_camera($urandom, rand_word(), rand_word());
            endcase
            if (ph == 0)
            begin
                // directed: extremes, every mode, camera at object, straight above
                for (int m = 0; m < 4; m++)
                begin
                    add_obj(make_obj(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 2'(m)));
                    add_obj(make_obj(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 2'(m)));
                    add_obj(make_obj(32'h0, 32'h0, 32'h0,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 2'(m)));
                    add_obj(make_obj(32'h0, 32'h0005_0000, 32'h0,
                        32'h0002_0000, 32'h0002_0000, 32'hfffe_0000, 2'(m)));
                end
                add_obj(make_obj(32'h0, 32'h8000_0000, 32'h0003_0000,
                    32'h0001_0000, 32'h0001_0000, 32'h0001_0000, MODE_LOCK_Z));
                add_obj(make_obj(32'h0004_0000, 32'h0001_0000, 32'h0003_0000,
                    32'h0001_0000, 32'h0001_0000, 32'h7fff_ffff, MODE_FULL));
            end
            for (int k = 0; k < 75; k++)
                add_obj(rand_obj());

            @(posedge clk);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 55; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            if (ph == 1)
                hold_req++;

            // sender pauses until every result of this phase is back
            wait (pending_objs.size() == 0 && !in_valid && expected_matrices.size() == 0);
            repeat (DRAIN_WAIT) @(posedge clk);
        end

        $display("Sent %0d objects and checked %0d matrices over 8 camera settings,",
                 n_in, n_out);
        $display("all billboard modes, with idle, stall and long hold-off phases.");
        if (errors == 0 && expected_matrices.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
